@@ src/assert_macros.svh @@
// Assertion macros for the checker of the edge interrupt controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GEIRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define GEIRQ_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ src/geirq_pkg.sv @@
// Shared types and constants of the GPIO edge interrupt controller.
`timescale 1ns / 1ps

package geirq_pkg;

	// Fixed field widths and the default pin count.
	localparam int PIN_IDX_W     = 6;
	localparam int LEVEL_W       = 64;
	localparam int CFG_W         = 64;
	localparam int DEF_PIN_COUNT = 64;

	// Item operation codes.
	typedef enum logic [2:0] {
		MODE_SAMPLE   = 3'd0,
		MODE_MASK     = 3'd1,
		MODE_MASK_ACK = 3'd2,
		MODE_UNMASK   = 3'd3,
		MODE_SERVICE  = 3'd4
	} mode_t;

	// Configuration register indexes.
	typedef enum logic {
		CFG_RISING_SELECT  = 1'b0,
		CFG_FALLING_SELECT = 1'b1
	} cfg_reg_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE     = 1'b0,
		ST_DISPATCH = 1'b1
	} state_t;

	typedef struct packed {
		logic [2:0]           mode;
		logic [LEVEL_W-1:0]   pin_levels;
		logic [PIN_IDX_W-1:0] pin_index;
	} in_item_t;

	typedef struct packed {
		logic [PIN_IDX_W-1:0] irq_pin;
		logic                 replayed;
		logic                 last;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;
		logic load_replay;
		logic pick;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic disp_any;
		logic replay_hit;
		logic pick_last;
	} dp_sts_t;

endpackage

@@ src/geirq_dp.sv @@
// Datapath: per-pin state masks, dispatch set and output register.
`timescale 1ns / 1ps

module geirq_dp import geirq_pkg::*; #(
	parameter int PIN_COUNT = DEF_PIN_COUNT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	output out_item_t        out_data
);

	logic [PIN_COUNT-1:0] rise_sel_q, fall_sel_q;
	logic [PIN_COUNT-1:0] level_q, pend_q;
	logic [PIN_COUNT-1:0] rise_en_q, fall_en_q;
	logic [PIN_COUNT-1:0] enab_q, spur_q;
	logic [PIN_COUNT-1:0] disp_q;
	out_item_t            out_q;

	logic [PIN_COUNT-1:0] sel;
	logic [PIN_COUNT-1:0] levels;
	logic [PIN_COUNT-1:0] hit_vec;
	logic [PIN_COUNT-1:0] spur_new;
	logic [PIN_COUNT-1:0] lowest;
	logic [PIN_IDX_W-1:0] low_idx;

	// One-hot select of the addressed pin; it is all zero for a pin out of range.
	assign sel    = {{(PIN_COUNT-1){1'b0}}, 1'b1} << in_data.pin_index;
	assign levels = in_data.pin_levels[PIN_COUNT-1:0];

	// Pins whose current level matches one of their selected edges.
	assign hit_vec  = (level_q & rise_sel_q) | (~level_q & fall_sel_q);
	assign spur_new = pend_q & ~enab_q;

	// Lowest pin still waiting for dispatch, and its number.
	assign lowest = disp_q & (~disp_q + PIN_COUNT'(1));

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < PIN_COUNT; i++) begin
			if (lowest[i]) begin
				low_idx = low_idx | PIN_IDX_W'(i);
			end
		end
	end

	assign sts.disp_any   = |(pend_q & enab_q);
	assign sts.replay_hit = |(sel & spur_q & hit_vec);
	assign sts.pick_last  = ~|(disp_q & ~lowest);

	// Edge select registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_sel_q <= '0;
			fall_sel_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RISING_SELECT:  rise_sel_q <= cfg_data[PIN_COUNT-1:0];
				CFG_FALLING_SELECT: fall_sel_q <= cfg_data[PIN_COUNT-1:0];
				default: ;
			endcase
		end
	end

	// Per-pin state updated by an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			pend_q    <= '0;
			rise_en_q <= '0;
			fall_en_q <= '0;
			enab_q    <= '0;
			spur_q    <= '0;
		end else if (cmd.exec) begin
			case (in_data.mode)
				MODE_SAMPLE: begin
					pend_q  <= pend_q | (~level_q & levels & rise_en_q)
						| (level_q & ~levels & fall_en_q);
					level_q <= levels;
				end
				MODE_MASK: begin
					spur_q <= spur_q & ~sel;
					enab_q <= enab_q & ~sel;
				end
				MODE_MASK_ACK: begin
					spur_q <= spur_q & ~sel;
					enab_q <= enab_q & ~sel;
					pend_q <= pend_q & ~sel;
				end
				MODE_UNMASK: begin
					if (!sts.replay_hit) begin
						enab_q    <= enab_q | sel;
						rise_en_q <= (rise_en_q & ~sel) | (rise_sel_q & sel);
						fall_en_q <= (fall_en_q & ~sel) | (fall_sel_q & sel);
					end
				end
				MODE_SERVICE: begin
					// Spurious pins are dropped, the rest move to the dispatch set.
					rise_en_q <= rise_en_q & ~(spur_new & spur_q);
					fall_en_q <= fall_en_q & ~(spur_new & spur_q);
					spur_q    <= spur_q | spur_new;
					pend_q    <= '0;
				end
				default: ;
			endcase
		end
	end

	// Dispatch set: loaded by service, emptied one pin per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q <= '0;
		end else if (cmd.exec && in_data.mode == MODE_SERVICE) begin
			disp_q <= pend_q & enab_q;
		end else if (cmd.pick) begin
			disp_q <= disp_q & ~lowest;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load_replay) begin
			out_q.irq_pin  <= in_data.pin_index;
			out_q.replayed <= 1'b1;
			out_q.last     <= 1'b1;
		end else if (cmd.pick) begin
			out_q.irq_pin  <= low_idx;
			out_q.replayed <= 1'b0;
			out_q.last     <= sts.pick_last;
		end
	end

	assign out_data = out_q;

endmodule

@@ src/geirq_ctrl.sv @@
// Controller: handshakes, output valid and the dispatch sequencer.
`timescale 1ns / 1ps

module geirq_ctrl import geirq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] mode,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free;
	logic   accept;

	// The output register can take a new result when empty or draining.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		in_stall        = 1'b1;
		accept          = 1'b0;
		out_valid_d     = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = !out_free;
				accept   = in_valid && out_free;
				cmd.exec = accept;
				if (accept && mode == MODE_UNMASK && sts.replay_hit) begin
					cmd.load_replay = 1'b1;
					out_valid_d     = 1'b1;
				end
				if (accept && mode == MODE_SERVICE && sts.disp_any) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (out_free) begin
					cmd.pick    = 1'b1;
					out_valid_d = 1'b1;
					if (sts.pick_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ src/gpio_edge_irq_demux_lazy_mask.sv @@
// Top level of the GPIO edge interrupt controller with lazy masking.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_item_t
//   out     | output    | out_valid/out_stall | out_item_t
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Sample, mask, mask-and-ack and unmask act when their item is accepted; an
// unmask replay shows its result in the output register on the next cycle.
// Service loads the dispatch set; its pins then leave lowest first, each as
// the single output register frees; the input stalls until the last is loaded.
// Reset clears every per-pin mask, the edge selects and the output valid.
// A stalled output holds its result and stalls the input, whatever the next
// item is, until that result is taken.
`timescale 1ns / 1ps

module gpio_edge_irq_demux_lazy_mask import geirq_pkg::*; #(
	parameter int PIN_COUNT = DEF_PIN_COUNT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencer.
	geirq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (in_data.mode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Pin state and results.
	geirq_dp #(
		.PIN_COUNT (PIN_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

@@ src/geirq_chk.sv @@
// Port-level checker for the edge interrupt controller, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module geirq_chk import geirq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A stalled result stays in place.
	`GEIRQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

	// A replayed interrupt is always the only result of its item.
	`GEIRQ_ASSERT(a_replay_last, out_valid && out_data.replayed |-> out_data.last, "replay not last")

	// Dispatched pins of one service item come out in ascending order.
	`GEIRQ_ASSERT(a_ascend, out_valid && !out_stall && !out_data.last |=> !out_valid || out_data.irq_pin > $past(out_data.irq_pin), "dispatch order broken")

	// No new item is taken while a dispatch burst is unfinished.
	`GEIRQ_NEVER(a_burst_stall, out_valid && !out_data.last && !in_stall, "input open during burst")

endmodule

bind gpio_edge_irq_demux_lazy_mask geirq_chk u_chk (.*);
